>>> rtl/core/spinab_pkg.sv
// Shared widths, register indexes and the configuration struct of the spin image unit.
`default_nettype none

package spinab_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int COEF_W     = 18;
    localparam int COEF_FRAC  = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // first rotation: coef * diff, two products summed
    localparam int P1_W = COEF_W + DIFF_W;
    localparam int S1_W = P1_W + 1;
    localparam int X1_W = S1_W - COEF_FRAC;
    // second rotation: coef * x1 and coef * dz
    localparam int P2_W = COEF_W + X1_W;
    localparam int S2_W = P2_W + 1;
    localparam int X2_W = S2_W - COEF_FRAC;

    // |x2| < 2^28, |y1| <= 2^26
    localparam int MAG_X_W = 28;
    localparam int MAG_Y_W = 27;

    localparam int ALPHA_W = 25;
    localparam int BETA_W  = 26;

    // square root: sum of squares stays below 2^55
    localparam int SQ_W  = 2 * MAG_X_W;
    localparam int RT_W  = SQ_W / 2;
    localparam int REM_W = RT_W + 2;

    localparam logic [ALPHA_W-1:0]       ALPHA_MAX = '1;
    localparam logic signed [BETA_W-1:0] BETA_MAX  = {1'b0, {(BETA_W-1){1'b1}}};
    localparam logic signed [BETA_W-1:0] BETA_MIN  = {1'b1, {(BETA_W-1){1'b0}}};

    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_A_COS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_A_SIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_B_SIN = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_B_COS = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COEF_W-1:0]  a_cos;
        logic signed [COEF_W-1:0]  a_sin;
        logic signed [COEF_W-1:0]  b_sin;
        logic signed [COEF_W-1:0]  b_cos;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/core/spinab_rotate.sv
// Origin subtract and the two plane rotations, five register stages.
`default_nettype none

module spinab_rotate
    import spinab_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  t_cfg                       i_cfg,
    input  wire                        i_valid,
    input  wire  signed [COORD_W-1:0]  i_point_x,
    input  wire  signed [COORD_W-1:0]  i_point_y,
    input  wire  signed [COORD_W-1:0]  i_point_z,
    output logic                       o_valid,
    output logic [MAG_X_W-1:0]         o_mag_x,
    output logic [MAG_Y_W-1:0]         o_mag_y,
    output logic signed [BETA_W-1:0]   o_beta
);

    localparam logic signed [S1_W-1:0] RND1 = S1_W'(64'd1 << (COEF_FRAC - 1));
    localparam logic signed [S2_W-1:0] RND2 = S2_W'(64'd1 << (COEF_FRAC - 1));

    logic [4:0] r_vld;

    // stage 1: differences
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz1;
    // stage 2: first rotation products
    logic signed [P1_W-1:0]   r_ca_dx, r_sa_dy, r_ca_dy, r_sa_dx;
    logic signed [DIFF_W-1:0] r_dz2;
    // stage 3: rounded x1, y1
    logic signed [X1_W-1:0]   r_x1, r_y1_3;
    logic signed [DIFF_W-1:0] r_dz3;
    // stage 4: second rotation products
    logic signed [P2_W-1:0]   r_cb_x1, r_sb_x1;
    logic signed [P1_W-1:0]   r_sb_dz, r_cb_dz;
    logic signed [X1_W-1:0]   r_y1_4;
    // stage 5: magnitudes and saturated beta
    logic [MAG_X_W-1:0]       r_mag_x;
    logic [MAG_Y_W-1:0]       r_mag_y;
    logic signed [BETA_W-1:0] r_beta;

    logic signed [DIFF_W-1:0] n_dx, n_dy, n_dz;
    logic signed [S1_W-1:0]   n_sum_x1, n_sum_y1;
    logic signed [S2_W-1:0]   n_sum_x2, n_sum_z2;
    logic signed [X2_W-1:0]   n_x2, n_z2;
    logic signed [X2_W-1:0]   n_abs_x2;
    logic signed [X1_W-1:0]   n_abs_y1;
    logic signed [BETA_W-1:0] n_beta;

    always_comb begin
        n_dx = DIFF_W'(i_point_x) - DIFF_W'(i_cfg.origin_x);
        n_dy = DIFF_W'(i_point_y) - DIFF_W'(i_cfg.origin_y);
        n_dz = DIFF_W'(i_point_z) - DIFF_W'(i_cfg.origin_z);

        n_sum_x1 = S1_W'(r_ca_dx) + S1_W'(r_sa_dy) + RND1;
        n_sum_y1 = S1_W'(r_ca_dy) - S1_W'(r_sa_dx) + RND1;

        n_sum_x2 = S2_W'(r_cb_x1) - S2_W'(r_sb_dz) + RND2;
        n_sum_z2 = S2_W'(r_sb_x1) + S2_W'(r_cb_dz) + RND2;
        n_x2     = n_sum_x2[S2_W-1:COEF_FRAC];
        n_z2     = n_sum_z2[S2_W-1:COEF_FRAC];

        n_abs_x2 = n_x2[X2_W-1] ? -n_x2 : n_x2;
        n_abs_y1 = r_y1_4[X1_W-1] ? -r_y1_4 : r_y1_4;

        if (n_z2 > X2_W'(BETA_MAX)) begin
            n_beta = BETA_MAX;
        end else if (n_z2 < X2_W'(BETA_MIN)) begin
            n_beta = BETA_MIN;
        end else begin
            n_beta = n_z2[BETA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_dz1    <= n_dz;

            r_ca_dx  <= P1_W'(i_cfg.a_cos) * P1_W'(r_dx);
            r_sa_dy  <= P1_W'(i_cfg.a_sin) * P1_W'(r_dy);
            r_ca_dy  <= P1_W'(i_cfg.a_cos) * P1_W'(r_dy);
            r_sa_dx  <= P1_W'(i_cfg.a_sin) * P1_W'(r_dx);
            r_dz2    <= r_dz1;

            r_x1     <= n_sum_x1[S1_W-1:COEF_FRAC];
            r_y1_3   <= n_sum_y1[S1_W-1:COEF_FRAC];
            r_dz3    <= r_dz2;

            r_cb_x1  <= P2_W'(i_cfg.b_cos) * P2_W'(r_x1);
            r_sb_x1  <= P2_W'(i_cfg.b_sin) * P2_W'(r_x1);
            r_sb_dz  <= P1_W'(i_cfg.b_sin) * P1_W'(r_dz3);
            r_cb_dz  <= P1_W'(i_cfg.b_cos) * P1_W'(r_dz3);
            r_y1_4   <= r_y1_3;

            r_mag_x  <= n_abs_x2[MAG_X_W-1:0];
            r_mag_y  <= n_abs_y1[MAG_Y_W-1:0];
            r_beta   <= n_beta;
        end
    end

    assign o_valid = r_vld[4];
    assign o_mag_x = r_mag_x;
    assign o_mag_y = r_mag_y;
    assign o_beta  = r_beta;

endmodule

`default_nettype wire

>>> rtl/core/spinab_sqrt.sv
// Sum of squares and a pipelined digit-by-digit square root with rounding and saturation.
`default_nettype none

module spinab_sqrt
    import spinab_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire  [MAG_X_W-1:0]         i_mag_x,
    input  wire  [MAG_Y_W-1:0]         i_mag_y,
    input  wire  signed [BETA_W-1:0]   i_beta,
    output logic                       o_valid,
    output logic [ALPHA_W-1:0]         o_alpha,
    output logic signed [BETA_W-1:0]   o_beta
);

    logic                     r_sq_vld, r_sum_vld, r_out_vld;
    logic [RT_W-1:0]          r_it_vld;

    logic [SQ_W-1:0]          r_sq_x, r_sq_y;
    logic [SQ_W-1:0]          r_sum;
    logic signed [BETA_W-1:0] r_beta_sq, r_beta_sum;

    logic [REM_W-1:0]         r_rem  [RT_W];
    logic [RT_W-1:0]          r_root [RT_W];
    logic [SQ_W-1:0]          r_rest [RT_W-1];
    logic signed [BETA_W-1:0] r_beta_it [RT_W];

    logic [ALPHA_W-1:0]       r_alpha;
    logic signed [BETA_W-1:0] r_beta_out;

    logic [REM_W-1:0]         w_prev_rem  [RT_W];
    logic [RT_W-1:0]          w_prev_root [RT_W];
    logic [SQ_W-1:0]          w_prev_rest [RT_W];
    logic signed [BETA_W-1:0] w_prev_beta [RT_W];

    logic [RT_W:0]            n_alpha_full;
    logic [ALPHA_W-1:0]       n_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
            r_it_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_sq_vld  <= i_valid;
            r_sum_vld <= r_sq_vld;
            r_it_vld  <= {r_it_vld[RT_W-2:0], r_sum_vld};
            r_out_vld <= r_it_vld[RT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x     <= SQ_W'(i_mag_x) * SQ_W'(i_mag_x);
            r_sq_y     <= SQ_W'(i_mag_y) * SQ_W'(i_mag_y);
            r_beta_sq  <= i_beta;
            r_sum      <= r_sq_x + r_sq_y;
            r_beta_sum <= r_beta_sq;
        end
    end

    // one result bit per stage, two radicand bits brought down each time
    for (genvar g = 0; g < RT_W; g++) begin : g_iter
        logic [REM_W+1:0] w_wide;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;

        if (g == 0) begin : g_first
            assign w_prev_rem[g]  = '0;
            assign w_prev_root[g] = '0;
            assign w_prev_rest[g] = r_sum;
            assign w_prev_beta[g] = r_beta_sum;
        end else begin : g_next
            assign w_prev_rem[g]  = r_rem[g-1];
            assign w_prev_root[g] = r_root[g-1];
            assign w_prev_rest[g] = r_rest[g-1];
            assign w_prev_beta[g] = r_beta_it[g-1];
        end

        assign w_wide  = {w_prev_rem[g], w_prev_rest[g][SQ_W-1 -: 2]};
        assign w_trial = {2'b00, w_prev_root[g], 2'b01};
        assign w_ge    = (w_wide >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]     <= w_ge ? REM_W'(w_wide - w_trial) : REM_W'(w_wide);
                r_root[g]    <= {w_prev_root[g][RT_W-2:0], w_ge};
                r_beta_it[g] <= w_prev_beta[g];
            end
        end

        if (g < RT_W - 1) begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rest[g] <= {w_prev_rest[g][SQ_W-3:0], 2'b00};
                end
            end
        end
    end

    // round up when the remainder exceeds the floor root
    always_comb begin
        n_alpha_full = {1'b0, r_root[RT_W-1]}
                     + (RT_W+1)'(r_rem[RT_W-1] > REM_W'(r_root[RT_W-1]));
        if (n_alpha_full > (RT_W+1)'(ALPHA_MAX)) begin
            n_alpha = ALPHA_MAX;
        end else begin
            n_alpha = n_alpha_full[ALPHA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha    <= n_alpha;
            r_beta_out <= r_beta_it[RT_W-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_alpha = r_alpha;
    assign o_beta  = r_beta_out;

endmodule

`default_nettype wire

>>> rtl/core/spin_image_alpha_beta_by_rotation_unit.sv
// An accepted item passes the rotation stages, the squaring, summing and root stages and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a valid result is stalled at the output.
// Depth is set by the square root, one result bit per stage (28 stages).
// Reset (synchronous, active low) empties the pipeline and restores the configuration
// defaults: origin zero, first rotation identity, second rotation sine term one.
// Top level of the spin image alpha/beta unit: configuration, flow control, checks.
`default_nettype none

module spin_image_alpha_beta_by_rotation_unit
    import spinab_pkg::*;
(
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire  [CFG_DATA_W-1:0]       i_cfg_wdata,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  signed [COORD_W-1:0]   i_point_x,
    input  wire  signed [COORD_W-1:0]   i_point_y,
    input  wire  signed [COORD_W-1:0]   i_point_z,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [ALPHA_W-1:0]          o_radial_alpha,
    output logic signed [BETA_W-1:0]    o_axial_beta
);

    t_cfg                     r_cfg;
    logic                     w_en;
    logic                     w_rot_valid;
    logic [MAG_X_W-1:0]       w_mag_x;
    logic [MAG_Y_W-1:0]       w_mag_y;
    logic signed [BETA_W-1:0] w_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.origin_z <= '0;
            r_cfg.a_cos    <= COEF_ONE;
            r_cfg.a_sin    <= '0;
            r_cfg.b_sin    <= COEF_ONE;
            r_cfg.b_cos    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_ORIGIN_X:  r_cfg.origin_x <= i_cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Y:  r_cfg.origin_y <= i_cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Z:  r_cfg.origin_z <= i_cfg_wdata[COORD_W-1:0];
                REG_ROT_A_COS: r_cfg.a_cos    <= i_cfg_wdata[COEF_W-1:0];
                REG_ROT_A_SIN: r_cfg.a_sin    <= i_cfg_wdata[COEF_W-1:0];
                REG_ROT_B_SIN: r_cfg.b_sin    <= i_cfg_wdata[COEF_W-1:0];
                REG_ROT_B_COS: r_cfg.b_cos    <= i_cfg_wdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline moves unless a result sits in the output register and is stalled
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    spinab_rotate u_rotate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_valid   (w_rot_valid),
        .o_mag_x   (w_mag_x),
        .o_mag_y   (w_mag_y),
        .o_beta    (w_beta)
    );

    spinab_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_valid),
        .i_mag_x (w_mag_x),
        .i_mag_y (w_mag_y),
        .i_beta  (w_beta),
        .o_valid (o_valid),
        .o_alpha (o_radial_alpha),
        .o_beta  (o_axial_beta)
    );

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // bubbles carry undefined data, so beta is only checked behind a valid item
    a_hold_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_rot_valid) && (!w_rot_valid || $stable(w_beta)))
        else $error("inner stage moved while the output was stalled");

    a_new_result_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_stall))
        else $error("result appeared while the pipeline was held");

endmodule

`default_nettype wire
